// ===== design/utf8d_pkg.sv =====
// Shared types, constants and the group-value function for the UTF-8 decoder.
// No dependencies; imported by every module of the decoder.
package utf8d_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } utf8d_in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        last_of_string;
  } utf8d_out_t;

  // Up to two results from one byte; res0 is always filled first.
  typedef struct packed {
    logic       vld0;
    logic       vld1;
    utf8d_out_t res0;
    utf8d_out_t res1;
  } utf8d_push_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [5:0] SixBits     = 6'h3F;
  localparam logic [2:0] MaxGroupLen = 3'd4;

  function automatic logic [20:0] group_value(
    input logic [7:0] lead,
    input logic [5:0] t0,
    input logic [5:0] t1,
    input logic [5:0] t2,
    input logic [2:0] len
  );
    logic [2:0]  need;
    logic [20:0] cp;
    logic        bad;
    bad  = 1'b0;
    need = 3'd1;
    cp   = '0;
    if (lead[7] == 1'b0) begin
      need = 3'd1;
      cp   = {13'd0, lead};
    end else if ((lead & 8'hE0) == 8'hC0) begin
      need = 3'd2;
      cp   = {10'd0, lead[4:0], t0};
    end else if ((lead & 8'hF0) == 8'hE0) begin
      need = 3'd3;
      cp   = {5'd0, lead[3:0], t0, t1};
    end else if ((lead & 8'hF8) == 8'hF0) begin
      need = 3'd4;
      cp   = {lead[2:0], t0, t1, t2};
    end else begin
      bad = 1'b1;
    end
    if (bad || (len < need)) begin
      return '0;
    end
    return cp;
  endfunction

endpackage

// ===== design/utf8d_group.sv =====
// Input stage and group tracker: registers each byte, updates the open group
// and forms up to two code-point results. Depends on utf8d_pkg.
module utf8d_group (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8d_pkg::utf8d_in_t  in_data_i,
  input  logic                  room_i,
  output logic                  stage_valid_o,
  output utf8d_pkg::utf8d_push_t push_o
);
  import utf8d_pkg::*;

  logic       valid_q;
  utf8d_in_t  data_q;
  logic       open_q, open_d;
  logic [7:0] lead_q, lead_d;
  logic [5:0] trail_q [3];
  logic [5:0] trail_d [3];
  logic [2:0] len_q, len_d;
  logic       fire, cont, close_old;
  logic [1:0] trail_idx;
  logic [20:0] old_cp, new_cp;

  assign fire          = valid_q && room_i;
  assign in_stall_o    = valid_q && !room_i;
  assign stage_valid_o = valid_q;

  assign cont      = (data_q.data_byte & ContMask) == ContTag;
  assign close_old = open_q && !cont;
  assign trail_idx = len_q[1:0] - 2'd1;

  always_comb begin
    open_d     = open_q;
    lead_d     = lead_q;
    trail_d[0] = trail_q[0];
    trail_d[1] = trail_q[1];
    trail_d[2] = trail_q[2];
    len_d      = len_q;
    if (open_q && cont) begin
      if (len_q < MaxGroupLen) begin
        trail_d[trail_idx] = data_q.data_byte[5:0] & SixBits;
        len_d              = len_q + 3'd1;
      end
    end else begin
      open_d     = 1'b1;
      lead_d     = data_q.data_byte;
      trail_d[0] = '0;
      trail_d[1] = '0;
      trail_d[2] = '0;
      len_d      = 3'd1;
    end
    if (data_q.end_of_string) begin
      open_d = 1'b0;
    end
  end

  assign old_cp = group_value(lead_q, trail_q[0], trail_q[1], trail_q[2], len_q);
  assign new_cp = group_value(lead_d, trail_d[0], trail_d[1], trail_d[2], len_d);

  always_comb begin
    push_o = '0;
    if (close_old) begin
      push_o.vld0                = fire;
      push_o.res0.code_point     = old_cp;
      push_o.res0.last_of_string = 1'b0;
      push_o.vld1                = fire && data_q.end_of_string;
      push_o.res1.code_point     = new_cp;
      push_o.res1.last_of_string = 1'b1;
    end else begin
      push_o.vld0                = fire && data_q.end_of_string;
      push_o.res0.code_point     = new_cp;
      push_o.res0.last_of_string = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      data_q     <= '0;
      open_q     <= 1'b0;
      lead_q     <= '0;
      trail_q[0] <= '0;
      trail_q[1] <= '0;
      trail_q[2] <= '0;
      len_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        valid_q <= in_valid_i;
        if (in_valid_i) begin
          data_q <= in_data_i;
        end
      end
      if (fire) begin
        open_q     <= open_d;
        lead_q     <= lead_d;
        trail_q[0] <= trail_d[0];
        trail_q[1] <= trail_d[1];
        trail_q[2] <= trail_d[2];
        len_q      <= len_d;
      end
    end
  end

endmodule

// ===== design/utf8d_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one beat a cycle
// while out_stall_i is low. Depends on utf8d_pkg.
module utf8d_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  utf8d_pkg::utf8d_push_t push_i,
  output logic                   room_o,
  output logic [utf8d_pkg::FifoCntW-1:0] count_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output utf8d_pkg::utf8d_out_t  out_data_o
);
  import utf8d_pkg::*;

  utf8d_out_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;
  logic [FifoCntW-1:0] n_push;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign count_o     = cnt_q;

  assign n_push  = FifoCntW'(push_i.vld0) + FifoCntW'(push_i.vld1);
  assign wr_next = wr_q + FifoPtrW'(1);
  assign wr_d    = wr_q + FifoPtrW'(n_push);
  assign rd_d    = rd_q + FifoPtrW'(pop);
  assign cnt_d   = cnt_q + n_push - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/utf8_to_codepoint_decoder.sv =====
// UTF-8 to code point decoder, top level. Instantiates utf8d_group and
// utf8d_out_fifo; types from utf8d_pkg.
//
// Takes one byte per cycle while in_stall_o is low and emits one 21-bit code
// point per closed group, with last_of_string on the final one of each
// string. A byte passes an input register, then the decode logic writes 0 to
// 2 results into a 4-entry result queue whose head drives the output. Input
// is held off only when the queue holds more than two results, so with the
// output never stalled the block sustains one byte per cycle; a byte that
// both closes a group and ends the string adds a second result, and results
// drain at one per cycle.
module utf8_to_codepoint_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8d_pkg::utf8d_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output utf8d_pkg::utf8d_out_t out_data_o
);
  import utf8d_pkg::*;

  utf8d_push_t         push;
  logic                room;
  logic                stage_valid;
  logic [FifoCntW-1:0] fifo_count;

  utf8d_group u_group (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .room_i        (room),
    .stage_valid_o (stage_valid),
    .push_o        (push)
  );

  utf8d_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // queue never overflows
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  // second result slot only used together with the first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld1 |-> push.vld0)
    else $error("second result without first");

  // input is held off only while a byte waits in the stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage_valid && !room))
    else $error("input stalled without a waiting byte");

  // a pushed pair is always the closing result followed by the string end
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld1 |-> (!push.res0.last_of_string && push.res1.last_of_string))
    else $error("bad result pair ordering");

endmodule

// ===== verif/tb_utf8_to_codepoint_decoder.sv =====
// Self-checking testbench for utf8_to_codepoint_decoder: bursty byte driver, stalling
// result monitor and a cycle-free code point predictor. Depends on utf8d_pkg and the design.
module tb_utf8_to_codepoint_decoder;
  import utf8d_pkg::*;

  typedef struct {
    utf8d_in_t beat;
    bit        drain_first;  // sender waits until all pending code points are out
    bit        rx_hold;      // receiver holds off for a long stretch once this is taken
  } tb_beat_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  localparam int unsigned NumBytes   = 1350;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MarkEvery  = 300;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  utf8d_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  utf8d_out_t out_data;

  utf8_to_codepoint_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tb_beat_t   beat_q[$];
  utf8d_out_t cp_exp_q[$];
  int         err_cnt = 0;
  int         out_cnt = 0;

  // predictor state
  bit         grp_open = 1'b0;
  logic [7:0] grp_lead = '0;
  logic [5:0] grp_trail[3];
  logic [2:0] grp_len = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [20:0] closed_cp();
    logic [2:0]  want;
    logic [20:0] v;
    v = '0;
    casez (grp_lead)
      8'b0???????: begin
        want = 3'd1;
        v    = {13'd0, grp_lead};
      end
      8'b110?????: begin
        want = 3'd2;
        v    = {10'd0, grp_lead[4:0], grp_trail[0]};
      end
      8'b1110????: begin
        want = 3'd3;
        v    = {5'd0, grp_lead[3:0], grp_trail[0], grp_trail[1]};
      end
      8'b11110???: begin
        want = 3'd4;
        v    = {grp_lead[2:0], grp_trail[0], grp_trail[1], grp_trail[2]};
      end
      default: want = 3'd7;  // continuation or F8..FF lead never completes
    endcase
    return (grp_len < want) ? 21'd0 : v;
  endfunction

  task automatic close_group(input logic last);
    utf8d_out_t r;
    r.code_point     = closed_cp();
    r.last_of_string = last;
    cp_exp_q.push_back(r);
  endtask

  task automatic decode_byte(input utf8d_in_t b);
    if (grp_open && (b.data_byte[7:6] == 2'b10)) begin
      if (grp_len < 3'd4) begin
        grp_trail[grp_len - 3'd1] = b.data_byte[5:0];
        grp_len                   = grp_len + 3'd1;
      end
    end else begin
      if (grp_open) close_group(1'b0);
      grp_open  = 1'b1;
      grp_lead  = b.data_byte;
      grp_trail = '{default: '0};
      grp_len   = 3'd1;
    end
    if (b.end_of_string) begin
      close_group(1'b1);
      grp_open = 1'b0;
    end
  endtask

  task automatic push_flagged(input logic [7:0] b, input logic eos, input bit drain,
                              input bit hold);
    tb_beat_t it;
    it.beat.data_byte     = b;
    it.beat.end_of_string = eos;
    it.drain_first        = drain;
    it.rx_hold            = hold;
    beat_q.push_back(it);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eos);
    push_flagged(b, eos, 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Mostly well-formed characters; some truncated, with extra continuation bytes, with a bad lead or stray.
  task automatic gen_string();
    logic [7:0] bytes_q[$];
    int         nchar;
    int         kind;
    int         len;
    int         conts;
    logic [7:0] lead;
    nchar = $urandom_range(1, 6);
    for (int c = 0; c < nchar; c++) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      case (len)
        1:       lead = {1'b0, 7'($urandom)};
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      conts = len - 1;
      if (kind < 8 && len > 1) conts = $urandom_range(0, len - 2);
      else if (kind < 13) conts = len - 1 + $urandom_range(1, 3);
      else if (kind < 16) lead = {5'b11111, 3'($urandom)};
      else if (kind < 19) lead = cont_byte();
      bytes_q.push_back(lead);
      for (int k = 0; k < conts; k++) bytes_q.push_back(cont_byte());
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i], (i == bytes_q.size() - 1));
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), ($urandom_range(0, 9) == 0));
  endtask

  // ---------------- driver ----------------
  int       burst_left = 0;
  int       gap_left   = 0;
  int       hold_reqs  = 0;
  logic     drv_busy;
  tb_beat_t drv_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      drv_busy = in_valid && in_stall;
      if (in_valid && !in_stall) decode_byte(in_data);
      if (!drv_busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() == 0 ||
                     (beat_q[0].drain_first && cp_exp_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          drv_next = beat_q.pop_front();
          in_data  <= drv_next.beat;
          in_valid <= 1'b1;
          if (drv_next.rx_hold) hold_reqs <= hold_reqs + 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // ---------------- receiver stall pattern ----------------
  rx_mode_e rx_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_FREE;
      mode_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------- monitor ----------------
  utf8d_out_t mon_exp;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (cp_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected code point %h last %b",
                                  out_data.code_point, out_data.last_of_string));
      end else begin
        mon_exp = cp_exp_q.pop_front();
        if (out_data.code_point !== mon_exp.code_point)
          report_mismatch($sformatf("beat %0d code_point %h, want %h", out_cnt,
                                    out_data.code_point, mon_exp.code_point));
        if (out_data.last_of_string !== mon_exp.last_of_string)
          report_mismatch($sformatf("beat %0d last_of_string %b, want %b", out_cnt,
                                    out_data.last_of_string, mon_exp.last_of_string));
      end
      out_cnt++;
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    int next_mark;
    bit mark_hold;
    // directed: ASCII extremes, each length, max 4-byte value
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b1);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b1);
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    // continuation with no group open
    push_byte(8'h80, 1'b1);
    // bad leads; the second byte closes one group and ends the string
    push_byte(8'hF8, 1'b0); push_byte(8'hFF, 1'b1);
    // truncated 3-byte group closed by ASCII
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'h41, 1'b1);
    // trailing continuations beyond the lead length
    push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h41, 1'b0); push_byte(8'h42, 1'b1);

    next_mark = MarkEvery;
    mark_hold = 1'b1;
    while (beat_q.size() < NumBytes) begin
      if (beat_q.size() >= next_mark) begin
        push_flagged({1'b0, 7'($urandom)}, 1'b0, !mark_hold, mark_hold);
        mark_hold = !mark_hold;
        next_mark += MarkEvery;
      end
      if ($urandom_range(0, 9) < 8) gen_string();
      else gen_noise();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_q.size() != 0 || in_valid) @(posedge clk_i);
    while (cp_exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/utf8d_pkg.sv
design/utf8d_group.sv
design/utf8d_out_fifo.sv
design/utf8_to_codepoint_decoder.sv
verif/tb_utf8_to_codepoint_decoder.sv
